// File: hw/rtl/sfrtq_pkg.sv
// ----------------------------------------------------------------------------
// sfrtq_pkg
// Types and constants of the sample frame ring transmit queue: request and
// result structs, operation codes, controller states and frame layout.
// ----------------------------------------------------------------------------
package sfrtq_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int FRAME_W     = FRAME_BYTES * 8;
  localparam int FCW         = $clog2(FRAME_BYTES);
  localparam logic [7:0] FRAME_END = 8'hAA;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_DONE   = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] reading;
    logic [15:0] freq_centi_hz;
    logic [6:0]  duty_percent;
    logic        excite_level;
    logic [9:0]  read_index;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic       duplicate;
    logic       chunk_start;
    logic [9:0] chunk_offset;
    logic [9:0] chunk_length;
    logic [9:0] fill_level;
    logic [7:0] read_data;
  } out_t;

endpackage

// File: hw/rtl/sample_frame_ring_transmit_queue_core.sv
// ----------------------------------------------------------------------------
// sample_frame_ring_transmit_queue_core
// Byte ring of sample frames with duplicate filter and contiguous chunk drain.
// Results are registered; a read byte also waits in ST_READ for the registered
// store read. An accepted sample is decided in ST_IDLE, then holds off new
// requests in ST_WRITE while its nine frame bytes go through the single store
// port; done and flush leave the controller in ST_IDLE.
// Reset: synchronous, clears pointers, drain state and the written mark; the
// store itself is not swept, unwritten bytes read as zero.
// ----------------------------------------------------------------------------
module sample_frame_ring_transmit_queue_core #(
  parameter int QUEUE_FRAMES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sfrtq_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sfrtq_pkg::out_t  out_data
);

  localparam int STORE_BYTES = QUEUE_FRAMES * sfrtq_pkg::FRAME_BYTES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int IW          = (AW > 10) ? AW : 10;
  localparam int NEED        = sfrtq_pkg::FRAME_BYTES + 1;
  localparam logic [AW-1:0] S_A   = STORE_BYTES[AW-1:0];
  localparam logic [AW:0]   S_X   = STORE_BYTES[AW:0];
  localparam logic [AW:0]   NEED_X = NEED[AW:0];
  localparam logic [AW:0]   FB_X  = sfrtq_pkg::FRAME_BYTES[AW:0];
  localparam logic [sfrtq_pkg::FCW-1:0] LAST_BYTE =
    sfrtq_pkg::FCW'(sfrtq_pkg::FRAME_BYTES - 1);

  // byte store
  logic [7:0] ring_store [STORE_BYTES];
  logic [7:0] rd_byte;
  logic [AW-1:0] mem_addr;
  logic mem_we;

  // control and ring state
  sfrtq_pkg::state_t state, state_next;
  logic [AW-1:0] write_pos, write_pos_next;
  logic [AW-1:0] read_pos, read_pos_next;
  logic [AW-1:0] issued_length, issued_length_next;
  logic          drain_busy, drain_busy_next;
  logic          wrapped, wrapped_next;
  logic [31:0]   previous_reading, previous_reading_next;
  logic          rd_ok, rd_ok_next;

  // frame write engine
  logic [sfrtq_pkg::FRAME_W-1:0] frame_sr;
  logic [AW-1:0]                 wr_ptr;
  logic [sfrtq_pkg::FCW-1:0]     byte_cnt;
  logic                          start_write;

  // per-request datapath
  logic                res_free, accept, load_out;
  sfrtq_pkg::out_t     out_next;
  logic [AW-1:0]       used_now, used_after;
  logic                room;
  logic [AW:0]         wp_sum, rp_sum;
  logic [AW-1:0]       wp_after, rp_after;
  logic [AW-1:0]       try_wp, try_rp;
  logic                try_busy, do_try, issue;
  logic [AW-1:0]       chunk_len;
  logic [IW-1:0]       idx_ext;
  logic [sfrtq_pkg::FRAME_W-1:0] frame;

  function automatic logic [AW-1:0] ring_used(input logic [AW-1:0] wp,
                                              input logic [AW-1:0] rp);
    if (wp >= rp) begin
      return wp - rp;
    end
    return S_A - (rp - wp);
  endfunction

  assign res_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign idx_ext  = IW'(in_data.read_index);
  assign frame    = {sfrtq_pkg::FRAME_END, 7'd0, in_data.excite_level, 1'b0,
                     in_data.duty_percent, in_data.freq_centi_hz, in_data.reading};

  always_comb begin
    state_next            = state;
    in_stall              = (state != sfrtq_pkg::ST_IDLE) || !res_free;
    load_out              = 1'b0;
    out_next              = '0;
    write_pos_next        = write_pos;
    read_pos_next         = read_pos;
    issued_length_next    = issued_length;
    drain_busy_next       = drain_busy;
    wrapped_next          = wrapped;
    previous_reading_next = previous_reading;
    rd_ok_next            = rd_ok;
    start_write           = 1'b0;
    mem_we                = 1'b0;
    mem_addr              = AW'(idx_ext);

    used_now = ring_used(write_pos, read_pos);
    room     = ({1'b0, used_now} + NEED_X) <= S_X;
    wp_sum   = {1'b0, write_pos} + FB_X;
    wp_after = (wp_sum >= S_X) ? AW'(wp_sum - S_X) : AW'(wp_sum);
    rp_sum   = {1'b0, read_pos} + {1'b0, issued_length};
    rp_after = (rp_sum >= S_X) ? AW'(rp_sum - S_X) : AW'(rp_sum);

    try_wp   = write_pos;
    try_rp   = read_pos;
    try_busy = drain_busy;
    do_try   = 1'b0;
    if (in_data.operation == sfrtq_pkg::OP_SAMPLE) begin
      try_wp = wp_after;
      do_try = (in_data.reading != previous_reading) && room;
    end else if (in_data.operation == sfrtq_pkg::OP_DONE) begin
      if (drain_busy) begin
        try_rp = rp_after;
      end
      try_busy = 1'b0;
      do_try   = 1'b1;
    end
    issue     = do_try && !try_busy && (try_wp != try_rp);
    chunk_len = (try_wp > try_rp) ? (try_wp - try_rp) : (S_A - try_rp);
    used_after = ring_used(try_wp, try_rp);

    case (state)
      sfrtq_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            sfrtq_pkg::OP_SAMPLE: begin
              load_out = 1'b1;
              previous_reading_next = in_data.reading;
              if (in_data.reading == previous_reading) begin
                out_next.duplicate  = 1'b1;
                out_next.fill_level = 10'(used_now);
              end else if (room) begin
                out_next.accepted   = 1'b1;
                out_next.fill_level = 10'(used_after);
                write_pos_next      = wp_after;
                if (wp_sum >= S_X) begin
                  wrapped_next = 1'b1;
                end
                start_write = 1'b1;
                state_next  = sfrtq_pkg::ST_WRITE;
              end else begin
                out_next.fill_level = 10'(used_now);
              end
            end
            sfrtq_pkg::OP_DONE: begin
              load_out            = 1'b1;
              read_pos_next       = try_rp;
              drain_busy_next     = 1'b0;
              issued_length_next  = '0;
              out_next.fill_level = 10'(used_after);
            end
            sfrtq_pkg::OP_FLUSH: begin
              load_out           = 1'b1;
              write_pos_next     = '0;
              read_pos_next      = '0;
              drain_busy_next    = 1'b0;
              issued_length_next = '0;
              wrapped_next       = 1'b0;
            end
            sfrtq_pkg::OP_READ: begin
              rd_ok_next = (idx_ext < IW'(STORE_BYTES)) &&
                           (wrapped || (idx_ext < IW'(write_pos)));
              state_next = sfrtq_pkg::ST_READ;
            end
            default: begin
              load_out = 1'b0;
            end
          endcase
          if (issue) begin
            out_next.chunk_start  = 1'b1;
            out_next.chunk_offset = 10'(try_rp);
            out_next.chunk_length = 10'(chunk_len);
            drain_busy_next       = 1'b1;
            issued_length_next    = chunk_len;
          end
        end
      end
      sfrtq_pkg::ST_WRITE: begin
        mem_we   = 1'b1;
        mem_addr = wr_ptr;
        if (byte_cnt == LAST_BYTE) begin
          state_next = sfrtq_pkg::ST_IDLE;
        end
      end
      sfrtq_pkg::ST_READ: begin
        if (res_free) begin
          load_out            = 1'b1;
          out_next.fill_level = 10'(used_now);
          out_next.read_data  = rd_ok ? rd_byte : 8'd0;
          state_next          = sfrtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sfrtq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_store[mem_addr] <= frame_sr[7:0];
    end
    rd_byte <= ring_store[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= sfrtq_pkg::ST_IDLE;
      write_pos        <= '0;
      read_pos         <= '0;
      issued_length    <= '0;
      drain_busy       <= 1'b0;
      wrapped          <= 1'b0;
      previous_reading <= '0;
      rd_ok            <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      write_pos        <= write_pos_next;
      read_pos         <= read_pos_next;
      issued_length    <= issued_length_next;
      drain_busy       <= drain_busy_next;
      wrapped          <= wrapped_next;
      previous_reading <= previous_reading_next;
      rd_ok            <= rd_ok_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
    if (start_write) begin
      frame_sr <= frame;
      wr_ptr   <= write_pos;
      byte_cnt <= '0;
    end else if (state == sfrtq_pkg::ST_WRITE) begin
      frame_sr <= frame_sr >> 8;
      wr_ptr   <= (wr_ptr == S_A - 1'b1) ? '0 : wr_ptr + 1'b1;
      byte_cnt <= byte_cnt + 1'b1;
    end
  end

endmodule

// File: tb/sample_frame_ring_transmit_queue_core_test.sv
// ----------------------------------------------------------------------------
// sample_frame_ring_transmit_queue_core_test
// Drives sample, chunk done, flush and read byte requests into the frame ring
// and checks every result field against a cycle-free model of the ring that
// lives in this file. Covers duplicates, ring full, wrapped chunks, flush and
// out-of-range reads, with random idling on both sides, a long output hold and
// a final stretch with no idling.
// ----------------------------------------------------------------------------
module sample_frame_ring_transmit_queue_core_test;
  import sfrtq_pkg::*;

  localparam int QUEUE_FRAMES = 64;
  localparam int STORE_BYTES  = QUEUE_FRAMES * FRAME_BYTES;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 400;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // ring model
  logic [7:0]  ring_mem [STORE_BYTES] = '{default: 8'h00};
  int          wr_ptr       = 0;
  int          rd_ptr       = 0;
  bit          drain_active = 1'b0;
  int          chunk_len    = 0;
  logic [31:0] last_reading = '0;

  out_t pending_results [$];

  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int stall_left   = 0;
  int error_count  = 0;
  int cycle_count  = 0;

  sample_frame_ring_transmit_queue_core #(
    .QUEUE_FRAMES(QUEUE_FRAMES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int ring_fill();
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : STORE_BYTES - (rd_ptr - wr_ptr);
  endfunction

  function automatic void start_chunk(inout out_t res);
    if (drain_active || wr_ptr == rd_ptr) return;
    chunk_len        = (wr_ptr > rd_ptr) ? wr_ptr - rd_ptr : STORE_BYTES - rd_ptr;
    drain_active     = 1'b1;
    res.chunk_start  = 1'b1;
    res.chunk_offset = 10'(rd_ptr);
    res.chunk_length = 10'(chunk_len);
  endfunction

  function automatic out_t predict_result(input in_t req);
    out_t               res;
    logic [FRAME_W-1:0] frame_bits;
    res = '0;
    case (req.operation)
      OP_SAMPLE: begin
        if (req.reading == last_reading) begin
          res.duplicate = 1'b1;
        end else if (STORE_BYTES - ring_fill() - 1 >= FRAME_BYTES) begin
          frame_bits = {FRAME_END, 7'd0, req.excite_level, 1'b0, req.duty_percent,
                        req.freq_centi_hz, req.reading};
          for (int i = 0; i < FRAME_BYTES; i++) begin
            ring_mem[wr_ptr] = frame_bits[8*i +: 8];
            wr_ptr = (wr_ptr + 1) % STORE_BYTES;
          end
          res.accepted = 1'b1;
          start_chunk(res);
        end
        last_reading = req.reading;
      end
      OP_DONE: begin
        if (drain_active) begin
          rd_ptr       = (rd_ptr + chunk_len) % STORE_BYTES;
          drain_active = 1'b0;
          chunk_len    = 0;
        end
        start_chunk(res);
      end
      OP_FLUSH: begin
        wr_ptr       = 0;
        rd_ptr       = 0;
        drain_active = 1'b0;
        chunk_len    = 0;
        foreach (ring_mem[i]) ring_mem[i] = 8'h00;
      end
      default: begin
        if (req.read_index < STORE_BYTES) res.read_data = ring_mem[req.read_index];
      end
    endcase
    res.fill_level = 10'(ring_fill());
    return res;
  endfunction

  function automatic in_t make_request(input op_t op, input logic [31:0] reading,
                                       input logic [15:0] freq, input logic [6:0] duty,
                                       input logic level, input logic [9:0] index);
    in_t req;
    req.operation     = op;
    req.reading       = reading;
    req.freq_centi_hz = freq;
    req.duty_percent  = duty;
    req.excite_level  = level;
    req.read_index    = index;
    return req;
  endfunction

  function automatic in_t random_request(input op_t op);
    logic [31:0] reading;
    logic [9:0]  index;
    case ($urandom_range(0, 7))
      0:       reading = last_reading;
      1:       reading = $urandom_range(0, 3);
      default: reading = $urandom;
    endcase
    index = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(STORE_BYTES, 1023))
                                        : 10'($urandom_range(0, STORE_BYTES - 1));
    return make_request(op, reading, 16'($urandom_range(0, 65535)),
                        7'($urandom_range(0, 100)), 1'($urandom_range(0, 1)), index);
  endfunction

  function automatic op_t pick_op(input int done_pct, input int flush_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < flush_pct) return OP_FLUSH;
    if (roll < flush_pct + done_pct) return OP_DONE;
    if (roll < flush_pct + done_pct + 15) return OP_READ;
    return OP_SAMPLE;
  endfunction

  task automatic send_request(input in_t req);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_result(req));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // output side idling and long hold
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: %h", out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", want.accepted, out_data.accepted);
        check_field("duplicate", want.duplicate, out_data.duplicate);
        check_field("chunk_start", want.chunk_start, out_data.chunk_start);
        check_field("chunk_offset", want.chunk_offset, out_data.chunk_offset);
        check_field("chunk_length", want.chunk_length, out_data.chunk_length);
        check_field("fill_level", want.fill_level, out_data.fill_level);
        check_field("read_data", want.read_data, out_data.read_data);
      end
    end
  end

  task automatic test_directed();
    send_request(make_request(OP_READ, 0, 0, 0, 0, 10'd575));
    send_request(make_request(OP_READ, 0, 0, 0, 0, 10'd1023));
    send_request(make_request(OP_SAMPLE, 32'd0, 16'd0, 7'd0, 1'b0, 0));
    send_request(make_request(OP_DONE, 0, 0, 0, 0, 0));
    send_request(make_request(OP_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 7'd100, 1'b1, 0));
    send_request(make_request(OP_SAMPLE, 32'hFFFF_FFFF, 16'h1234, 7'd5, 1'b0, 0));
    send_request(make_request(OP_SAMPLE, 32'd1, 16'd0, 7'd0, 1'b0, 0));
    send_request(make_request(OP_READ, 0, 0, 0, 0, 10'd0));
    send_request(make_request(OP_READ, 0, 0, 0, 0, 10'd6));
    send_request(make_request(OP_READ, 0, 0, 0, 0, 10'd7));
    send_request(make_request(OP_READ, 0, 0, 0, 0, 10'd8));
    send_request(make_request(OP_DONE, 0, 0, 0, 0, 0));
    send_request(make_request(OP_DONE, 0, 0, 0, 0, 0));
    send_request(make_request(OP_DONE, 0, 0, 0, 0, 0));
    send_request(make_request(OP_FLUSH, 0, 0, 0, 0, 0));
    send_request(make_request(OP_READ, 0, 0, 0, 0, 10'd8));
    send_request(make_request(OP_SAMPLE, 32'd1, 16'd7, 7'd3, 1'b1, 0));
    send_request(make_request(OP_SAMPLE, 32'h8000_0001, 16'h5A5A, 7'd64, 1'b1, 0));
    send_request(make_request(OP_READ, 0, 0, 0, 0, 10'd9));
  endtask

  task automatic test_ring_full();
    send_request(make_request(OP_FLUSH, 0, 0, 0, 0, 0));
    hold_request = 1'b1;
    repeat (90) send_request(random_request(OP_SAMPLE));
    repeat (3) send_request(random_request(OP_DONE));
    repeat (4) send_request(random_request(OP_SAMPLE));
    repeat (3) send_request(random_request(OP_DONE));
    repeat (6) send_request(random_request(OP_READ));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int done_pct;
    int flush_pct;
    int burst;
    repeat (8) begin
      case ($urandom_range(0, 2))
        0: begin
          done_pct = 1;  flush_pct = 0; burst = 80;
        end
        1: begin
          done_pct = 25; flush_pct = 2; burst = 50;
        end
        default: begin
          done_pct = 45; flush_pct = 1; burst = 40;
        end
      endcase
      repeat (burst) send_request(random_request(pick_op(done_pct, flush_pct)));
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
  endtask

  task automatic test_quiet_traffic();
    idle_on = 1'b0;
    repeat (60) send_request(random_request(pick_op(30, 2)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_ring_full();
    test_random_traffic();
    test_quiet_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
